@@ sv/mitrk_pkg.sv @@
package mitrk_pkg;

  // Timer and report cadence
  localparam logic [31:0] TICK_MS      = 32'd1000;
  localparam logic [7:0]  REPORT_TICKS = 8'd10;
  localparam logic [31:0] STILL_MAX    = 32'hFFFF_FFFF;

  // Reset values of the configuration registers
  localparam logic [17:0] MOTION_THR_RST = 18'd4000;
  localparam logic [31:0] LOST_THR_RST   = 32'd12000;

  // floor(d / 1000) == (d * RECIP_1000) >> RECIP_SHIFT for any 32-bit d
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned PROD_W      = 61;
  localparam int unsigned SECS_W      = 23;

  // Configuration register indexes
  localparam logic CFG_MOTION_THR = 1'b0;
  localparam logic CFG_LOST_THR   = 1'b1;

  // Link actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_HIDE      = 2'd1;
  localparam logic [1:0] ACT_ADVERTISE = 2'd2;

  // LED patterns
  localparam logic [1:0] LED_ACTIVE = 2'b11;
  localparam logic [1:0] LED_LOST   = 2'b00;
  localparam logic [1:0] LED_REPORT = 2'b10;

  typedef struct packed {
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic signed [15:0] prev_z;
    logic [31:0]        still_ms;
    logic               lost;
    logic               hidden;
    logic               report_pending;
    logic [7:0]         report_phase;
    logic [1:0]         led;
  } state_t;

  // Everything of one result except the seconds, which the divide stage adds
  typedef struct packed {
    logic        moved;
    logic        lost;
    logic        discoverable;
    logic [1:0]  link_action;
    logic        report_valid;
    logic [31:0] still_ms;
    logic [1:0]  led_pattern;
  } result_t;

endpackage

@@ sv/motion_inactivity_lost_tracker.sv @@
// Motion and inactivity tracker. Each s_axis transaction is one timer tick with an
// accelerometer sample; each tick yields exactly one m_axis transaction. Ticks are taken
// back to back, one per cycle, while m_axis does not stall. A result is offered on m_axis
// once it has gone through both registered stages, one after the other:
// the first stage applies the tick to the tracker state and registers the result, the
// second multiplies the time spent lost by a fixed reciprocal of 1000 to get whole seconds.
// Each stage holds its result while the next one is full. With a result waiting on m_axis
// the first stage still takes one more tick; after that s_axis_tready stays low until
// m_axis drains. Configuration writes take effect on the next tick; write them only while
// no tick is in flight.
module motion_inactivity_lost_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // Tick input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // moved[0], lost[1], discoverable[2],
                                     // link_action[4:3], report_valid[5],
                                     // seconds_lost[28:6], still_ms[60:29],
                                     // led_pattern[62:61], zero[63]
);

  logic [17:0]         motion_thr_q;
  logic [31:0]         lost_thr_q;
  mitrk_pkg::state_t   state_q, state_d;
  mitrk_pkg::result_t  step_res;
  logic [31:0]         step_lost_ms;

  logic                s1_valid_q;
  mitrk_pkg::result_t  s1_res_q;
  logic [31:0]         s1_lost_ms_q;
  logic                s2_valid_q;
  mitrk_pkg::result_t  s2_res_q;
  logic [mitrk_pkg::PROD_W-1:0] s2_prod_q;

  logic in_fire, s1_ready, s2_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_thr_q <= mitrk_pkg::MOTION_THR_RST;
      lost_thr_q   <= mitrk_pkg::LOST_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mitrk_pkg::CFG_MOTION_THR: motion_thr_q <= cfg_wdata_i[17:0];
        mitrk_pkg::CFG_LOST_THR:   lost_thr_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Per-tick state update and result
  mitrk_step u_step (
    .state_i      (state_q),
    .motion_thr_i (motion_thr_q),
    .lost_thr_i   (lost_thr_q),
    .accel_x_i    (s_axis_tdata[15:0]),
    .accel_y_i    (s_axis_tdata[31:16]),
    .accel_z_i    (s_axis_tdata[47:32]),
    .state_o      (state_d),
    .result_o     (step_res),
    .lost_ms_o    (step_lost_ms)
  );

  // Each stage advances when it is empty or its successor takes its contents
  assign s2_ready      = !s2_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign in_fire       = s_axis_tvalid && s1_ready;

  // Tracker state: commit on every accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.prev_x         <= '0;
      state_q.prev_y         <= '0;
      state_q.prev_z         <= '0;
      state_q.still_ms       <= '0;
      state_q.lost           <= 1'b0;
      state_q.hidden         <= 1'b1;
      state_q.report_pending <= 1'b0;
      state_q.report_phase   <= '0;
      state_q.led            <= mitrk_pkg::LED_ACTIVE;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage payloads; hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_res_q     <= step_res;
      s1_lost_ms_q <= step_lost_ms;
    end
    if (s2_ready && s1_valid_q) begin
      s2_res_q  <= s1_res_q;
      // Widen before the multiply so the full product is kept
      s2_prod_q <= {29'd0, s1_lost_ms_q} * mitrk_pkg::RECIP_1000;
    end
  end

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {
    1'b0,
    s2_res_q.led_pattern,
    s2_res_q.still_ms,
    s2_prod_q[mitrk_pkg::PROD_W-1:mitrk_pkg::RECIP_SHIFT],
    s2_res_q.report_valid,
    s2_res_q.link_action,
    s2_res_q.discoverable,
    s2_res_q.lost,
    s2_res_q.moved
  };

  // A lost tracker is always advertising
  a_lost_not_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.lost |-> !state_q.hidden)
    else $error("lost mode with radio hidden");

  // A report goes out only in lost mode, and only from a quiet tick
  a_report_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_res_q.report_valid) |-> (s2_res_q.lost && !s2_res_q.moved))
    else $error("report outside lost mode");

  // Advertising starts together with lost mode
  a_advertise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_res_q.link_action == mitrk_pkg::ACT_ADVERTISE)
      |-> (s2_res_q.lost && s2_res_q.discoverable))
    else $error("advertise without lost mode");

  // A motion tick clears the still time
  a_motion_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && step_res.moved) |=> (state_q.still_ms == '0 && !state_q.lost))
    else $error("motion did not clear still time");

endmodule

@@ sv/mitrk_step.sv @@
module mitrk_step (
  input  mitrk_pkg::state_t  state_i,
  input  logic [17:0]        motion_thr_i,
  input  logic [31:0]        lost_thr_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output mitrk_pkg::state_t  state_o,
  output mitrk_pkg::result_t result_o,
  output logic [31:0]        lost_ms_o
);

  logic [32:0]        still_sum;
  logic [31:0]        still_tick;
  logic [7:0]         phase_inc;
  logic signed [16:0] dx, dy, dz;
  logic [16:0]        ax, ay, az;
  logic [18:0]        move_sum;
  logic               moved;
  logic [1:0]         action;
  logic               report;

  // Absolute axis changes against the previous sample
  assign dx = {accel_x_i[15], accel_x_i} - {state_i.prev_x[15], state_i.prev_x};
  assign dy = {accel_y_i[15], accel_y_i} - {state_i.prev_y[15], state_i.prev_y};
  assign dz = {accel_z_i[15], accel_z_i} - {state_i.prev_z[15], state_i.prev_z};
  assign ax = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay = dy[16] ? 17'(-dy) : 17'(dy);
  assign az = dz[16] ? 17'(-dz) : 17'(dz);
  assign move_sum = {2'b00, ax} + {2'b00, ay} + {2'b00, az};
  assign moved    = move_sum > {1'b0, motion_thr_i};

  // Saturating still time
  assign still_sum  = {1'b0, state_i.still_ms} + {1'b0, mitrk_pkg::TICK_MS};
  assign still_tick = still_sum[32] ? mitrk_pkg::STILL_MAX : still_sum[31:0];
  assign phase_inc  = state_i.report_phase + 8'd1;

  always_comb begin
    state_o          = state_i;
    state_o.prev_x   = accel_x_i;
    state_o.prev_y   = accel_y_i;
    state_o.prev_z   = accel_z_i;
    state_o.still_ms = still_tick;
    action           = mitrk_pkg::ACT_NONE;
    report           = 1'b0;
    lost_ms_o        = '0;

    if (phase_inc >= mitrk_pkg::REPORT_TICKS) begin
      state_o.report_phase   = '0;
      state_o.report_pending = 1'b1;
    end else begin
      state_o.report_phase = phase_inc;
    end

    if (moved) begin
      state_o.led          = mitrk_pkg::LED_ACTIVE;
      state_o.lost         = 1'b0;
      state_o.still_ms     = '0;
      state_o.report_phase = '0;
      if (!state_i.hidden) begin
        state_o.hidden = 1'b1;
        action         = mitrk_pkg::ACT_HIDE;
      end
    end else if (still_tick >= lost_thr_i && !state_i.lost) begin
      state_o.lost = 1'b1;
      state_o.led  = mitrk_pkg::LED_LOST;
      if (state_i.hidden) begin
        state_o.hidden = 1'b0;
        action         = mitrk_pkg::ACT_ADVERTISE;
      end
    end

    if (state_o.lost && state_o.report_pending) begin
      // Clamp to zero when the threshold sits above the still time
      if (state_o.still_ms >= lost_thr_i) begin
        lost_ms_o = state_o.still_ms - lost_thr_i;
      end
      report                 = 1'b1;
      state_o.report_pending = 1'b0;
      state_o.led            = mitrk_pkg::LED_REPORT;
    end

    result_o.moved        = moved;
    result_o.lost         = state_o.lost;
    result_o.discoverable = !state_o.hidden;
    result_o.link_action  = action;
    result_o.report_valid = report;
    result_o.still_ms     = state_o.still_ms;
    result_o.led_pattern  = state_o.led;
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import mitrk_pkg::*;

  // Run limits
  localparam int CYCLE_LIMIT  = 200_000;  // far above the slowest correct run
  localparam int DRAIN_CYCLES = 4;        // extra wait after the last expected result
  localparam int PHASE_TICKS  = 285;      // minimum ticks per random phase
  localparam int NUM_PHASES   = 6;
  localparam int unsigned MS_PER_S = 1000;

  // One result transaction, most significant field first (matches m_axis_tdata[62:0])
  typedef struct packed {
    logic [1:0]  led_pattern;
    logic [31:0] still_ms;
    logic [22:0] seconds_lost;
    logic        report_valid;
    logic [1:0]  link_action;
    logic        discoverable;
    logic        lost;
    logic        moved;
  } tick_result_t;

  // Directed row: a sample sent reps times, with an optional hand-written result
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         reps;
    logic               typed;
    tick_result_t       want;
  } tick_row_t;

  localparam tick_result_t NO_WANT = '0;

  // Walk from reset with the reset thresholds (4000 motion, 12000 ms lost):
  // extremes of all axes, motion sum right at and just above the threshold,
  // then stillness until lost mode starts and the pending report goes out.
  localparam tick_row_t WARMUP [8] = '{
    // first tick after reset: still time grows, nothing else happens
    '{16'sd0, 16'sd0, 16'sd0, 8'd1, 1'b1,
      '{LED_ACTIVE, 32'd1000, 23'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0}},
    // full-scale jumps: motion, radio already hidden so no link action
    '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 8'd1, 1'b1,
      '{LED_ACTIVE, 32'd0, 23'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b1}},
    '{16'sh8000, 16'sh7FFF, 16'sh8000, 8'd1, 1'b1,
      '{LED_ACTIVE, 32'd0, 23'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b1}},
    // sum exactly at the threshold is not motion, one above is
    '{-16'sd28768, 16'sh7FFF, 16'sh8000, 8'd1, 1'b0, NO_WANT},
    '{-16'sd24767, 16'sh7FFF, 16'sh8000, 8'd1, 1'b0, NO_WANT},
    // stillness; the report flag is raised on the tenth tick
    '{-16'sd24767, 16'sh7FFF, 16'sh8000, 8'd11, 1'b0, NO_WANT},
    // twelfth still tick: lost, advertise, and the pending report is sent at once
    '{-16'sd24767, 16'sh7FFF, 16'sh8000, 8'd1, 1'b1,
      '{LED_REPORT, 32'd12000, 23'd0, 1'b1, ACT_ADVERTISE, 1'b1, 1'b1, 1'b0}},
    '{-16'sd24767, 16'sh7FFF, 16'sh8000, 8'd1, 1'b0, NO_WANT}
  };

  // Random phases: thresholds and flow-control mix
  int unsigned phase_motion [NUM_PHASES] = '{4000, 0, 196605, 1500, 100000, 4000};
  int unsigned phase_lost   [NUM_PHASES] = '{12000, 0, 5000, 30000, 32'hFFFF_FFFF, 12000};
  int          phase_src    [NUM_PHASES] = '{0, 65, 0, 23, 65, 23};
  int          phase_sink   [NUM_PHASES] = '{0, 0, 65, 23, 0, 23};

  // DUT signals
  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = CFG_MOTION_THR;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // moved[0], lost[1], discoverable[2], link_action[4:3],
                                    // report_valid[5], seconds_lost[28:6], still_ms[60:29],
                                    // led_pattern[62:61], zero[63]

  // Tracker state mirrored by the testbench, reset values included
  logic [17:0]        motion_thr_q = MOTION_THR_RST;
  logic [31:0]        lost_thr_q   = LOST_THR_RST;
  logic signed [15:0] prev_x_q     = '0;
  logic signed [15:0] prev_y_q     = '0;
  logic signed [15:0] prev_z_q     = '0;
  logic [31:0]        still_q      = '0;
  logic               lost_q       = 1'b0;
  logic               hidden_q     = 1'b1;
  logic               pending_q    = 1'b0;
  logic [7:0]         phase_q      = '0;
  logic [1:0]         led_q        = LED_ACTIVE;

  // Flow control and bookkeeping
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cycle_count    = 0;
  int ticks_sent     = 0;
  int results_seen   = 0;
  int fail_count     = 0;
  int reports_due    = 0;
  int adverts_due    = 0;
  int hides_due      = 0;

  tick_result_t tick_results_due [$];

  motion_inactivity_lost_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the pipeline hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned axis_change(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Advance the mirrored tracker by one tick and return the result it yields
  function automatic tick_result_t track_tick(input logic signed [15:0] x,
                                              input logic signed [15:0] y,
                                              input logic signed [15:0] z);
    tick_result_t r;
    int unsigned  motion_sum;
    r = '0;
    // timer part: saturate the still time, step the report cadence
    if (still_q > STILL_MAX - TICK_MS) still_q = STILL_MAX;
    else still_q = still_q + TICK_MS;
    phase_q = phase_q + 8'd1;
    if (phase_q >= REPORT_TICKS) begin
      phase_q   = '0;
      pending_q = 1'b1;
    end
    motion_sum = axis_change(x, prev_x_q) + axis_change(y, prev_y_q)
               + axis_change(z, prev_z_q);
    prev_x_q = x;
    prev_y_q = y;
    prev_z_q = z;
    r.moved = (motion_sum > motion_thr_q);
    if (r.moved) begin
      // motion: back to active, restart the still clock, keep any pending report
      led_q   = LED_ACTIVE;
      lost_q  = 1'b0;
      still_q = '0;
      phase_q = '0;
      if (!hidden_q) begin
        hidden_q      = 1'b1;
        r.link_action = ACT_HIDE;
      end
    end else if (still_q >= lost_thr_q && !lost_q) begin
      lost_q = 1'b1;
      led_q  = LED_LOST;
      if (hidden_q) begin
        hidden_q      = 1'b0;
        r.link_action = ACT_ADVERTISE;
      end
    end
    if (lost_q && pending_q) begin
      // threshold raised above the still time: seconds stay at zero
      if (still_q >= lost_thr_q) r.seconds_lost = 23'((still_q - lost_thr_q) / MS_PER_S);
      r.report_valid = 1'b1;
      pending_q      = 1'b0;
      led_q          = LED_REPORT;
    end
    r.lost         = lost_q;
    r.discoverable = !hidden_q;
    r.still_ms     = still_q;
    r.led_pattern  = led_q;
    return r;
  endfunction

  // Send one tick; queue the hand-written result if given, else the mirrored one
  task automatic apply_tick(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic signed [15:0] z, input logic use_want,
                            input tick_result_t want);
    tick_result_t predicted;
    predicted = track_tick(x, y, z);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tick_results_due.push_back(use_want ? want : predicted);
    ticks_sent++;
    if (predicted.report_valid) reports_due++;
    if (predicted.link_action == ACT_ADVERTISE) adverts_due++;
    if (predicted.link_action == ACT_HIDE) hides_due++;
  endtask

  // Drain the pipeline, then load both thresholds
  task automatic load_thresholds(input logic [17:0] motion_thr, input logic [31:0] lost_thr);
    s_axis_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MOTION_THR;
    cfg_wdata_i <= {14'd0, motion_thr};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LOST_THR;
    cfg_wdata_i <= lost_thr;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    motion_thr_q  = motion_thr;
    lost_thr_q    = lost_thr;
  endtask

  // Move an axis by at most +/- span, clamped to the 16-bit range
  function automatic logic signed [15:0] nudge(input logic signed [15:0] base, input int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // One run of stillness (repeats and sub-threshold jitter, some noise),
  // closed by a full-range sample that usually counts as motion
  task automatic send_still_run();
    int                 run_len;
    int                 span;
    int                 i;
    logic signed [15:0] x, y, z;
    run_len = $urandom_range(0, 30);
    span    = int'(motion_thr_q) / 3;
    for (i = 0; i <= run_len; i++) begin
      if (i == run_len || $urandom_range(0, 19) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end else if ($urandom_range(0, 2) == 0) begin
        x = nudge(prev_x_q, span);
        y = nudge(prev_y_q, span);
        z = nudge(prev_z_q, span);
      end else begin
        x = prev_x_q;
        y = prev_y_q;
        z = prev_z_q;
      end
      apply_tick(x, y, z, 1'b0, NO_WANT);
    end
  endtask

  // Receiver: stall at random per the current mix
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Result checker: compare each transaction with the oldest expectation
  tick_result_t mon_want;
  tick_result_t mon_got;
  string        mon_bad;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tick_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with nothing expected: %h", m_axis_tdata);
      end else begin
        mon_want = tick_results_due.pop_front();
        mon_got  = tick_result_t'(m_axis_tdata[62:0]);
        mon_bad  = "";
        if (mon_got.moved !== mon_want.moved) mon_bad = {mon_bad, " moved"};
        if (mon_got.lost !== mon_want.lost) mon_bad = {mon_bad, " lost"};
        if (mon_got.discoverable !== mon_want.discoverable) mon_bad = {mon_bad, " discoverable"};
        if (mon_got.link_action !== mon_want.link_action) mon_bad = {mon_bad, " link_action"};
        if (mon_got.report_valid !== mon_want.report_valid) mon_bad = {mon_bad, " report_valid"};
        if (mon_got.seconds_lost !== mon_want.seconds_lost) mon_bad = {mon_bad, " seconds_lost"};
        if (mon_got.still_ms !== mon_want.still_ms) mon_bad = {mon_bad, " still_ms"};
        if (mon_got.led_pattern !== mon_want.led_pattern) mon_bad = {mon_bad, " led_pattern"};
        if (m_axis_tdata[63] !== 1'b0) mon_bad = {mon_bad, " pad"};
        if (mon_bad != "") begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d wrong in%s: expected %h, got %h",
                     results_seen, mon_bad, {1'b0, mon_want}, m_axis_tdata);
        end
        results_seen++;
      end
    end
  end

  // Stimulus
  initial begin
    int p;
    int r;
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk with reset thresholds and no idling
    for (r = 0; r < 8; r++) begin
      for (n = 0; n < int'(WARMUP[r].reps); n++)
        apply_tick(WARMUP[r].x, WARMUP[r].y, WARMUP[r].z, WARMUP[r].typed, WARMUP[r].want);
    end
    // Raise the lost threshold while lost: the next report carries zero seconds
    load_thresholds(MOTION_THR_RST, 32'hFFFF_FFFF);
    for (n = 0; n < 7; n++)
      apply_tick(prev_x_q, prev_y_q, prev_z_q, 1'b0, NO_WANT);

    // Random phases, state carried across threshold changes
    for (p = 0; p < NUM_PHASES; p++) begin
      load_thresholds(18'(phase_motion[p]), phase_lost[p]);
      src_idle_pct   = phase_src[p];
      sink_stall_pct = phase_sink[p];
      n = ticks_sent + PHASE_TICKS;
      while (ticks_sent < n) send_still_run();
    end

    // Drain and settle
    s_axis_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results from %0d ticks over %0d threshold settings, idle mixes %s",
             results_seen, ticks_sent, NUM_PHASES + 2, "none/sender/receiver/both");
    $display("Lost reports: %0d, advertise actions: %0d, hide actions: %0d, failures: %0d",
             reports_due, adverts_due, hides_due, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
